>>> rtl/stq_pkg.sv
package stq_pkg;

    localparam int MAX_TIMERS = 16;
    localparam int TICK_BITS  = 32;
    localparam int RESULT_CAP = 16;

    localparam int ID_W   = 4;
    localparam int DLY_W  = 32;
    localparam int NT_W   = 32;
    localparam int IDX_W  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int LEN_W  = $clog2(MAX_TIMERS + 1);
    localparam int CNT_W  = $clog2(RESULT_CAP + 1);
    localparam int CMP_W  = (TICK_BITS > NT_W) ? TICK_BITS : NT_W;
    localparam int CFG_W  = 32;
    localparam int CFGI_W = 2;

    typedef logic [TICK_BITS-1:0] t_tick;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [LEN_W-1:0]     t_len;

    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_DEL  = 2'd1,
        MODE_TICK = 2'd2,
        MODE_BAD  = 2'd3
    } t_mode;

    typedef enum logic [CFGI_W-1:0] {
        CFG_RUNNING  = 2'd0,
        CFG_TICKLESS = 2'd1,
        CFG_MAX_IDLE = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_DEQ, S_WRITE, S_SCAN, S_INSERT,
        S_AFTER, S_CHK, S_FIRE, S_NT, S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic meta_clr;
        logic set_err;
        logic tick_inc;
        logic deq;
        logic arm;
        logic clr_period;
        logic pos_inc;
        logic insert;
        logic fire;
        logic set_last;
        logic last_val;
        logic nt;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  bad_id;
        logic  queued;
        logic  running;
        logic  full;
        logic  scan_go;
        logic  due;
        logic  cnt_nz;
        logic  head_periodic;
    } t_stat;

    function automatic logic later(t_tick a, t_tick b);
        t_tick d;
        d = a - b;
        return (d != '0) && !d[TICK_BITS-1];
    endfunction

endpackage

>>> rtl/stq_req_if.sv
interface stq_req_if;
    import stq_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [ID_W-1:0]  timer_id;
    logic [DLY_W-1:0] delay;
    logic [DLY_W-1:0] period;
    modport source (output valid, mode, timer_id, delay, period, input ready);
    modport sink   (input valid, mode, timer_id, delay, period, output ready);
endinterface

>>> rtl/stq_rsp_if.sv
interface stq_rsp_if;
    import stq_pkg::*;
    logic             valid;
    logic             ready;
    logic             status;
    logic             fired;
    logic [ID_W-1:0]  fired_timer;
    logic             last;
    logic [NT_W-1:0]  next_timeout;
    logic [4:0]       queued_count;
    modport source (output valid, status, fired, fired_timer, last, next_timeout,
                    queued_count, input ready);
    modport sink   (input valid, status, fired, fired_timer, last, next_timeout,
                    queued_count, output ready);
endinterface

>>> rtl/stq_ctrl.sv
module stq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  stq_pkg::t_stat  i_stat,
    output stq_pkg::t_cmd   o_cmd
);
    import stq_pkg::*;

    t_state r_state, n_state;
    logic   r_more, n_more;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_more  <= n_more;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_more      = r_more;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.meta_clr = 1'b1;
                n_more         = 1'b0;
                if (i_stat.mode == MODE_BAD ||
                    ((i_stat.mode == MODE_ADD || i_stat.mode == MODE_DEL) && i_stat.bad_id)) begin
                    o_cmd.set_err = 1'b1;
                    n_state       = S_NT;
                end else if (i_stat.mode == MODE_TICK) begin
                    if (i_stat.running) begin
                        o_cmd.tick_inc = 1'b1;
                        n_state        = S_CHK;
                    end else begin
                        n_state = S_NT;
                    end
                end else if (i_stat.queued) begin
                    n_state = S_DEQ;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_DEQ: begin
                o_cmd.deq = 1'b1;
                n_state   = S_WRITE;
            end
            S_WRITE: begin
                if (i_stat.mode == MODE_ADD) begin
                    o_cmd.arm = 1'b1;
                    n_state   = S_SCAN;
                end else begin
                    o_cmd.clr_period = 1'b1;
                    n_state          = S_NT;
                end
            end
            S_SCAN: begin
                if (i_stat.full) begin
                    n_state = S_AFTER;
                end else if (i_stat.scan_go) begin
                    o_cmd.pos_inc = 1'b1;
                end else begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_AFTER;
            end
            S_AFTER: begin
                n_state = (i_stat.mode == MODE_TICK) ? S_CHK : S_NT;
            end
            S_CHK: begin
                if (!i_stat.cnt_nz) begin
                    n_state = i_stat.due ? S_FIRE : S_NT;
                end else begin
                    o_cmd.set_last = 1'b1;
                    o_cmd.last_val = !i_stat.due;
                    n_more         = i_stat.due;
                    n_state        = S_NT;
                end
            end
            S_FIRE: begin
                o_cmd.fire = 1'b1;
                n_more     = 1'b0;
                n_state    = i_stat.head_periodic ? S_SCAN : S_CHK;
            end
            S_NT: begin
                o_cmd.nt = 1'b1;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = r_more ? S_FIRE : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> rtl/stq_dp.sv
module stq_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  stq_pkg::t_cmd              i_cmd,
    output stq_pkg::t_stat             o_stat,
    input  logic                       i_cfg_we,
    input  logic [stq_pkg::CFGI_W-1:0] i_cfg_idx,
    input  logic [stq_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [1:0]                 i_mode,
    input  logic [stq_pkg::ID_W-1:0]   i_timer_id,
    input  logic [stq_pkg::DLY_W-1:0]  i_delay,
    input  logic [stq_pkg::DLY_W-1:0]  i_period,
    output logic                       o_status,
    output logic                       o_fired,
    output logic [stq_pkg::ID_W-1:0]   o_fired_timer,
    output logic                       o_last,
    output logic [stq_pkg::NT_W-1:0]   o_next_timeout,
    output logic [4:0]                 o_queued_count
);
    import stq_pkg::*;

    logic                r_running, r_tickless;
    logic [NT_W-1:0]     r_max_idle;
    t_tick               r_tick;
    t_len                r_len;
    logic [MAX_TIMERS-1:0] r_queued;
    logic [CNT_W-1:0]    r_cnt;
    t_len                r_pos;

    t_tick               r_exp [MAX_TIMERS];
    logic [DLY_W-1:0]    r_per [MAX_TIMERS];
    t_idx                r_ord [MAX_TIMERS];

    t_mode               r_mode;
    logic [DLY_W-1:0]    r_delay, r_period;
    logic                r_bad_id;
    t_idx                r_slot;
    t_tick               r_ins_exp;

    logic                r_status, r_fired, r_last;
    logic [NT_W-1:0]     r_nt;

    t_tick               head_exp;
    logic [DLY_W-1:0]    head_per;
    t_tick               scan_exp;
    t_idx                found_idx;
    t_idx                deq_idx;
    t_tick               rearm_exp;
    t_tick               rem;
    logic [NT_W-1:0]     nt_val;

    always_comb begin
        found_idx = '0;
        for (int k = MAX_TIMERS - 1; k >= 0; k--) begin
            if (LEN_W'(k) < r_len && r_ord[k] == r_slot) begin
                found_idx = IDX_W'(k);
            end
        end
    end

    assign head_exp  = r_exp[r_ord[0]];
    assign head_per  = r_per[r_ord[0]];
    assign scan_exp  = r_exp[r_ord[r_pos[IDX_W-1:0]]];
    assign deq_idx   = i_cmd.fire ? '0 : found_idx;
    assign rearm_exp = r_tick + TICK_BITS'(head_per);

    always_comb begin
        rem = TICK_BITS'(0);
        if (r_len != '0 && later(head_exp, r_tick)) begin
            rem = head_exp - r_tick;
        end
        if (!r_tickless || r_len == '0 || CMP_W'(rem) > CMP_W'(r_max_idle)) begin
            nt_val = r_max_idle;
        end else begin
            nt_val = NT_W'(rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_tickless <= 1'b0;
            r_max_idle <= '1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RUNNING:  r_running  <= i_cfg_data[0];
                CFG_TICKLESS: r_tickless <= i_cfg_data[0];
                CFG_MAX_IDLE: r_max_idle <= NT_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_len    <= '0;
            r_queued <= '0;
            r_cnt    <= '0;
            r_pos    <= '0;
        end else begin
            if (i_cmd.tick_inc) begin
                r_tick <= r_tick + TICK_BITS'(1);
                r_cnt  <= '0;
            end
            if (i_cmd.arm || (i_cmd.fire && head_per != '0)) begin
                r_pos <= '0;
            end else if (i_cmd.pos_inc) begin
                r_pos <= r_pos + LEN_W'(1);
            end
            if (i_cmd.deq || i_cmd.fire) begin
                r_len <= r_len - LEN_W'(1);
                if (i_cmd.fire) begin
                    r_queued[r_ord[0]] <= 1'b0;
                    r_cnt              <= r_cnt + CNT_W'(1);
                end else begin
                    r_queued[r_slot] <= 1'b0;
                end
            end
            if (i_cmd.insert) begin
                r_len            <= r_len + LEN_W'(1);
                r_queued[r_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= t_mode'(i_mode);
            r_delay  <= i_delay;
            r_period <= i_period;
            r_bad_id <= (int'(i_timer_id) >= MAX_TIMERS);
            r_slot   <= IDX_W'(i_timer_id);
        end
        if (i_cmd.meta_clr) begin
            r_status <= 1'b0;
            r_fired  <= 1'b0;
            r_last   <= 1'b1;
        end
        if (i_cmd.set_err) begin
            r_status <= 1'b1;
        end
        if (i_cmd.set_last) begin
            r_last <= i_cmd.last_val;
        end
        if (i_cmd.nt) begin
            r_nt <= nt_val;
        end
        if (i_cmd.deq || i_cmd.fire) begin
            for (int k = 0; k < MAX_TIMERS - 1; k++) begin
                if (IDX_W'(k) >= deq_idx) begin
                    r_ord[k] <= r_ord[k+1];
                end
            end
        end
        if (i_cmd.arm) begin
            r_exp[r_slot] <= r_tick + TICK_BITS'(r_delay);
            r_per[r_slot] <= r_period;
            r_ins_exp     <= r_tick + TICK_BITS'(r_delay);
        end
        if (i_cmd.clr_period) begin
            r_per[r_slot] <= '0;
        end
        if (i_cmd.fire) begin
            r_slot  <= r_ord[0];
            r_fired <= 1'b1;
            r_last  <= 1'b0;
            if (head_per != '0) begin
                r_exp[r_ord[0]] <= rearm_exp;
                r_ins_exp       <= rearm_exp;
            end
        end
        if (i_cmd.insert) begin
            for (int k = 1; k < MAX_TIMERS; k++) begin
                if (LEN_W'(k) > r_pos) begin
                    r_ord[k] <= r_ord[k-1];
                end
            end
            r_ord[r_pos[IDX_W-1:0]] <= r_slot;
        end
    end

    always_comb begin
        o_stat.mode          = r_mode;
        o_stat.bad_id        = r_bad_id;
        o_stat.queued        = r_queued[r_slot];
        o_stat.running       = r_running;
        o_stat.full          = (r_len >= LEN_W'(MAX_TIMERS));
        o_stat.scan_go       = (r_pos < r_len) && !later(scan_exp, r_ins_exp);
        o_stat.due           = (int'(r_cnt) < RESULT_CAP) && (r_len != '0)
                               && !later(head_exp, r_tick);
        o_stat.cnt_nz        = (r_cnt != '0);
        o_stat.head_periodic = (head_per != '0);
    end

    assign o_status       = r_status;
    assign o_fired        = r_fired;
    assign o_fired_timer  = r_fired ? ID_W'(r_slot) : '0;
    assign o_last         = r_last;
    assign o_next_timeout = r_nt;
    assign o_queued_count = 5'(r_len);

    a_len_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_queued) == int'(r_len))
        else $error("queued bits disagree with queue length");
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_len) <= MAX_TIMERS)
        else $error("queue length overflow");
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= RESULT_CAP)
        else $error("fire count beyond cap");

endmodule

>>> rtl/software_timer_queue_top.sv
// Sorted software timer queue.
// i_req (valid/ready) carries one request: mode add, delete or tick, with
// timer_id, delay and period. o_rsp (valid/ready) returns results; each
// add, delete, invalid request or idle tick gives one result, a tick that
// expires timers gives one result per expired timer with last on the final.
// i_cfg_we/i_cfg_idx/i_cfg_data write kernel_running, tickless_enable and
// max_idle_ticks; write only while no transaction is in progress.
// One item is in work at a time; i_req.ready is high only when idle.
// An add finds its place by an insertion scan, one queue entry per cycle;
// an add or delete of a slot that is already queued first takes it out.
// A tick that expires timers emits one result per timer, each after the
// previous is taken; a periodic one is rearmed and reinserted by the scan.
// Reset (synchronous, active low) empties the queue, zeroes the tick count
// and restores the registers to stopped, tickless off, idle limit all ones.
// When o_rsp is stalled the result holds and the block waits.
module software_timer_queue_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    stq_req_if.sink                    i_req,
    stq_rsp_if.source                  o_rsp,
    input  logic                       i_cfg_we,
    input  logic [stq_pkg::CFGI_W-1:0] i_cfg_idx,
    input  logic [stq_pkg::CFG_W-1:0]  i_cfg_data
);
    import stq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    stq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    stq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (i_req.mode),
        .i_timer_id     (i_req.timer_id),
        .i_delay        (i_req.delay),
        .i_period       (i_req.period),
        .o_status       (o_rsp.status),
        .o_fired        (o_rsp.fired),
        .o_fired_timer  (o_rsp.fired_timer),
        .o_last         (o_rsp.last),
        .o_next_timeout (o_rsp.next_timeout),
        .o_queued_count (o_rsp.queued_count)
    );

endmodule

>>> tb/stq_checker.sv
`timescale 1ns / 1ps
module stq_checker
    import stq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    stq_req_if                req,
    stq_rsp_if                rsp,
    input  logic              i_cfg_we,
    input  logic [CFGI_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_fired
);

    typedef struct {
        logic            status;
        logic            fired;
        logic [ID_W-1:0] slot;
        logic            last;
        logic [NT_W-1:0] next_to;
        logic [4:0]      count;
    } t_result;

    t_result   results_due[$];
    logic      run_en;
    logic      tickless;
    t_tick     idle_limit;
    t_tick     now;
    t_tick     expiry[MAX_TIMERS];
    t_tick     reload[MAX_TIMERS];
    t_idx      order[MAX_TIMERS];
    int        depth;
    bit        armed[MAX_TIMERS];

    assign o_pending = results_due.size();

    function automatic bit is_later(t_tick a, t_tick b);
        t_tick d;
        d = a - b;
        return (d != '0) && !d[TICK_BITS-1];
    endfunction

    function automatic void unlink(t_idx s);
        for (int i = 0; i < depth; i++) begin
            if (order[i] == s) begin
                for (int j = i; j + 1 < depth; j++) order[j] = order[j+1];
                depth--;
                break;
            end
        end
        armed[s] = 0;
    endfunction

    function automatic void link(t_idx s);
        int pos;
        pos = 0;
        if (depth >= MAX_TIMERS) return;
        while (pos < depth && !is_later(expiry[order[pos]], expiry[s])) pos++;
        for (int j = depth; j > pos; j--) order[j] = order[j-1];
        order[pos] = s;
        depth++;
        armed[s] = 1;
    endfunction

    function automatic t_tick ticks_to_head();
        t_tick remain;
        remain = idle_limit;
        if (!tickless) return idle_limit;
        if (depth > 0) begin
            if (!is_later(expiry[order[0]], now)) remain = '0;
            else remain = expiry[order[0]] - now;
        end
        return (remain > idle_limit) ? idle_limit : remain;
    endfunction

    function automatic void push_result(logic st, logic fi, t_idx s, logic lst);
        t_result r;
        r.status  = st;
        r.fired   = fi;
        r.slot    = s;
        r.last    = lst;
        r.next_to = ticks_to_head();
        r.count   = depth[4:0];
        results_due.push_back(r);
    endfunction

    function automatic void apply_request(t_mode m, t_idx id, t_tick dly, t_tick per);
        int n;
        t_idx h;
        n = 0;
        case (m)
            MODE_ADD, MODE_DEL: begin
                if (armed[id]) unlink(id);
                if (m == MODE_ADD) begin
                    expiry[id] = now + dly;
                    reload[id] = per;
                    link(id);
                end else begin
                    reload[id] = '0;
                end
                push_result(0, 0, 0, 1);
            end
            MODE_BAD: push_result(1, 0, 0, 1);
            default: begin
                if (!run_en) begin
                    push_result(0, 0, 0, 1);
                end else begin
                    now = now + 1;
                    while (n < RESULT_CAP && depth > 0) begin
                        h = order[0];
                        if (is_later(expiry[h], now)) break;
                        unlink(h);
                        if (reload[h] != '0) begin
                            expiry[h] = now + reload[h];
                            link(h);
                        end
                        push_result(0, 1, h, 0);
                        n++;
                    end
                    if (n == 0) push_result(0, 0, 0, 1);
                    else results_due[results_due.size()-1].last = 1;
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            run_en     = 0;
            tickless   = 0;
            idle_limit = '1;
            now        = '0;
            depth      = 0;
            for (int i = 0; i < MAX_TIMERS; i++) armed[i] = 0;
            results_due.delete();
            o_errors <= 0;
            o_fired  <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_RUNNING:  run_en     = i_cfg_data[0];
                    CFG_TICKLESS: tickless   = i_cfg_data[0];
                    CFG_MAX_IDLE: idle_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result st=%0d fired=%0d slot=%0d last=%0d nt=%0d cnt=%0d",
                             $time, rsp.status, rsp.fired, rsp.fired_timer, rsp.last,
                             rsp.next_timeout, rsp.queued_count);
                    o_errors <= o_errors + 1;
                end else begin
                    e = results_due.pop_front();
                    if (rsp.status !== e.status || rsp.fired !== e.fired ||
                        rsp.fired_timer !== e.slot || rsp.last !== e.last ||
                        rsp.next_timeout !== e.next_to || rsp.queued_count !== e.count) begin
                        $display("%0t: mismatch exp st=%0d fired=%0d slot=%0d last=%0d nt=%0d cnt=%0d",
                                 $time, e.status, e.fired, e.slot, e.last, e.next_to, e.count);
                        $display("%0t:          got st=%0d fired=%0d slot=%0d last=%0d nt=%0d cnt=%0d",
                                 $time, rsp.status, rsp.fired, rsp.fired_timer, rsp.last,
                                 rsp.next_timeout, rsp.queued_count);
                        o_errors <= o_errors + 1;
                    end
                    if (rsp.fired === 1'b1) o_fired <= o_fired + 1;
                end
            end
            if (req.valid && req.ready)
                apply_request(t_mode'(req.mode), req.timer_id, req.delay, req.period);
        end
    end

endmodule

>>> tb/software_timer_queue_top_test.sv
`timescale 1ns / 1ps
module software_timer_queue_top_test;
    import stq_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CFGI_W-1:0] cfg_idx;
    logic [CFG_W-1:0]  cfg_data;
    int                errors;
    int                pending;
    int                fired;
    int                send_idle;
    int                rcv_idle;
    int                n_items;

    stq_req_if req();
    stq_rsp_if rsp();

    software_timer_queue_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .o_rsp(rsp),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    stq_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req), .rsp(rsp),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_fired(fired)
    );

    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    initial rsp.ready = 1'b0;
    always @(posedge i_clk) rsp.ready <= ($urandom_range(99) >= rcv_idle);

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    task automatic send(t_mode m, logic [3:0] id, logic [31:0] dly, logic [31:0] per);
        if ($urandom_range(99) < send_idle) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        req.valid    <= 1'b1;
        req.mode     <= m;
        req.timer_id <= id;
        req.delay    <= dly;
        req.period   <= per;
        do @(posedge i_clk); while (!req.ready);
        n_items++;
    endtask

    task automatic quiesce();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic cfg_set(logic run, logic tl, logic [31:0] lim);
        cfg_write(CFG_RUNNING, {31'd0, run});
        cfg_write(CFG_TICKLESS, {31'd0, tl});
        cfg_write(CFG_MAX_IDLE, lim);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_item();
        int r;
        logic [31:0] dly, per;
        r = $urandom_range(99);
        case ($urandom_range(9))
            0: dly = $urandom();
            1: dly = 32'h7FFF_FFF0 + $urandom_range(0, 31);
            default: dly = $urandom_range(0, 12);
        endcase
        case ($urandom_range(19))
            0, 1, 2: per = $urandom();
            3: per = 32'h8000_0000;
            4, 5, 6, 7, 8, 9, 10: per = $urandom_range(1, 10);
            default: per = '0;
        endcase
        if (r < 45)      send(MODE_TICK, 4'($urandom_range(15)), $urandom(), $urandom());
        else if (r < 82) send(MODE_ADD, 4'($urandom_range(15)), dly, per);
        else if (r < 96) send(MODE_DEL, 4'($urandom_range(15)), $urandom(), $urandom());
        else             send(MODE_BAD, 4'($urandom_range(15)), $urandom(), $urandom());
    endtask

    initial begin
        req.valid    <= 1'b0;
        req.mode     <= MODE_ADD;
        req.timer_id <= '0;
        req.delay    <= '0;
        req.period   <= '0;
        cfg_we       <= 1'b0;
        cfg_idx      <= CFG_RUNNING;
        cfg_data     <= '0;
        i_rst_n      <= 1'b0;
        send_idle = 0;
        rcv_idle  = 0;
        n_items   = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // stopped kernel, bad mode, idle delete
        send(MODE_TICK, 4'd0, '0, '0);
        send(MODE_ADD, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(MODE_TICK, 4'd0, '0, '0);
        send(MODE_BAD, 4'd3, 32'hFFFF_FFFF, '0);
        send(MODE_DEL, 4'd7, '0, '0);
        send(MODE_DEL, 4'd15, '0, '0);
        quiesce();

        cfg_set(1'b1, 1'b1, 32'hFFFF_FFFF);
        send(MODE_TICK, 4'd0, '0, '0);
        // all slots due at once, one periodic
        for (int i = 0; i < MAX_TIMERS; i++)
            send(MODE_ADD, i[3:0], 32'd1, (i == 5) ? 32'd3 : 32'd0);
        send(MODE_TICK, 4'd0, '0, '0);
        // re-armed expiry still due
        send(MODE_ADD, 4'd2, 32'd0, 32'h8000_0000);
        send(MODE_ADD, 4'd9, 32'h7FFF_FFFF, 32'd0);
        send(MODE_TICK, 4'd0, '0, '0);
        send(MODE_TICK, 4'd0, '0, '0);
        quiesce();

        send_idle = 8;
        rcv_idle  = 85;
        cfg_set(1'b1, 1'b1, 32'd5);
        repeat (110) random_item();
        quiesce();

        send_idle = 85;
        rcv_idle  = 8;
        cfg_set(1'b1, 1'b0, 32'd0);
        repeat (60) random_item();
        quiesce();
        cfg_set(1'b1, 1'b1, 32'd0);
        repeat (40) random_item();
        quiesce();

        send_idle = 0;
        rcv_idle  = 0;
        cfg_set(1'b1, 1'b1, 32'hFFFF_FFFF);
        repeat (100) random_item();
        quiesce();
        cfg_set(1'b0, 1'b1, 32'd1000);
        repeat (20) random_item();
        quiesce();

        $display("Ran %0d requests, %0d expired timers reported,", n_items, fired);
        $display("under stopped/running kernel, tickless on/off and idle limits 0 to max.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
